### rtl/efwd_pkg.sv
// ============================================================================
// efwd_pkg: shared types and constants of the four-wheel drive controller
// Request and direction codes, register indexes, reset values and the small
// structs that pass between the controller's modules.
// ============================================================================
`default_nettype none

package efwd_pkg;

   // Motor count is fixed by the drive train.
   localparam int MOTOR_COUNT = 4;
   localparam int MOTOR_IDX_W = 2;

   // Request codes of an input item.
   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_DRIVE  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_BRAKE  = 2'd3
   } req_code_type;

   // Drive directions.
   typedef enum logic [1:0] {
      DIR_FRONT = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_BACK  = 2'd3
   } dir_code_type;

   // Register indexes of the write port.
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIM_0      = 3'd0,
      CSR_TRIM_1      = 3'd1,
      CSR_TRIM_2      = 3'd2,
      CSR_TRIM_3      = 3'd3,
      CSR_WALL_LIMIT  = 3'd4,
      CSR_STEER_GAIN  = 3'd5
   } csr_index_type;

   localparam int CSR_DATA_W = 16;
   localparam int TRIM_W     = 16;
   localparam int DIST_W     = 8;
   localparam int GAIN_W     = 4;
   localparam int SPEED_W    = 9;
   localparam int PWM_W      = 8;

   // Reset values of the registers; entry 0 belongs to motor 0.
   localparam logic [MOTOR_COUNT-1:0][TRIM_W-1:0] TRIM_RESET =
      {16'd32768, 16'd31345, 16'd31813, 16'd32664};
   localparam logic [DIST_W-1:0] WALL_LIMIT_RESET = 8'd10;
   localparam logic [GAIN_W-1:0] STEER_GAIN_RESET = 4'd1;

   // Wall steering term and duty scaling.
   localparam int WALL_W = 14;
   localparam logic [WALL_W-1:0] WALL_FAR_STEP = 14'd20;
   localparam int CLAMP_W = 25;
   localparam logic [CLAMP_W-1:0] ABS_LIMIT = 25'h100_0000;
   localparam int DUTY_SHIFT = 15;
   localparam logic [DUTY_SHIFT-1:0] ROUND_BIAS = 15'd16384;
   localparam logic [PWM_W-1:0] PWM_MAX = 8'd255;

   // Controls of the step counter bank.
   typedef struct packed {
      logic sample;
      logic clear;
   } cnt_ctrl_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

### rtl/efwd_counts.sv
// ============================================================================
// efwd_counts: encoder step counters
// Holds one wrapping step count and the last encoder level per motor. A
// sample counts rising encoder edges; a clear sets every count back to one.
// ============================================================================
`default_nettype none

module efwd_counts
   import efwd_pkg::*;
#(
   parameter int STEP_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cnt_ctrl_type                          ctrl,
   input  logic [MOTOR_COUNT-1:0]                enc_levels,
   output logic [MOTOR_COUNT-1:0][STEP_BITS-1:0] step_count
);

   logic [MOTOR_COUNT-1:0][STEP_BITS-1:0] count_ff, count_in;
   logic [MOTOR_COUNT-1:0]                level_ff, level_in;

   // Edge detection and count update per motor.
   always_comb begin
      count_in = count_ff;
      level_in = level_ff;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         if (ctrl.sample) begin
            if (enc_levels[i] && !level_ff[i]) begin
               count_in[i] = count_ff[i] + STEP_BITS'(1);
            end
            level_in[i] = enc_levels[i];
         end else if (ctrl.clear) begin
            count_in[i] = STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= {MOTOR_COUNT{STEP_BITS'(1)}};
         level_ff <= '0;
      end else begin
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

   assign step_count = count_ff;

endmodule

`default_nettype wire

### rtl/efwd_div.sv
// ============================================================================
// efwd_div: shared restoring divider
// Unsigned division, one quotient bit per cycle. The quotient is valid in
// the cycle in which done is high.
// ============================================================================
`default_nettype none

module efwd_div
   import efwd_pkg::*;
#(
   parameter int NUM_W = 30,
   parameter int DEN_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_status_type   status,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One shift and trial subtraction per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quo         = quo_ff;

`ifndef ASSERT_OFF
   // Done and busy never overlap.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider done while still busy");

   // Done follows the last step of a running division.
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && ($past(cnt_ff) == CNT_W'(1)))
      else $error("divider done without a final step");

   // A new division only starts on an idle unit.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

### rtl/encoder_balanced_four_wheel_drive.sv
// ============================================================================
// encoder_balanced_four_wheel_drive: four-motor drive with encoder balancing
// Sample and count-reset items give no result and do not stall the input. A brake
// item gives four results, one per cycle when the result side does not stall.
// A drive item gives four results too; for each motor whose count is not zero
// it uses the shared divider, which delivers one quotient bit per cycle.
// Reset (synchronous) sets counts to one, levels and the result valid to zero,
// and the registers to their defaults; no result is pending after reset.
// ============================================================================
`default_nettype none

module encoder_balanced_four_wheel_drive
   import efwd_pkg::*;
#(
   parameter int STEP_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [MOTOR_COUNT-1:0]    req_enc_levels,
   input  logic [1:0]                req_direction,
   input  logic signed [SPEED_W-1:0] req_speed,
   input  logic                      req_wall_left,
   input  logic                      req_wall_right,
   input  logic [DIST_W-1:0]         req_dist_left_front,
   input  logic [DIST_W-1:0]         req_dist_left_rear,
   input  logic [DIST_W-1:0]         req_dist_right_front,
   input  logic [DIST_W-1:0]         req_dist_right_rear,
   // Result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [MOTOR_IDX_W-1:0]    rsp_motor_index,
   output logic [PWM_W-1:0]          rsp_pwm_duty,
   output logic                      rsp_drive_a,
   output logic                      rsp_drive_b,
   output logic                      rsp_last_of_run,
   // Register writes
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int TW       = STEP_BITS + 2;
   localparam int KW       = STEP_BITS + 6;
   localparam int KMAG_W   = STEP_BITS + 5;
   localparam int VMAG_W   = SPEED_W;
   localparam int NW       = KMAG_W + VMAG_W;
   localparam int DW       = STEP_BITS + 2;
   localparam int CW       = NW + 2;
   localparam int MW       = (CW > CLAMP_W) ? CW : CLAMP_W;
   localparam int PROD_W   = CLAMP_W + TRIM_W;
   localparam int SCALED_W = PROD_W - DUTY_SHIFT;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SUM  = 8'b0000_0010,
      ST_LOAD = 8'b0000_0100,
      ST_MUL  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_ADJ  = 8'b0010_0000,
      ST_DUTY = 8'b0100_0000,
      ST_EMIT = 8'b1000_0000
   } state_type;

   // Control state
   state_type              state_ff, state_in;
   logic [MOTOR_IDX_W-1:0] motor_ff, motor_in;
   logic                   brake_ff, brake_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Captured item fields
   logic [1:0]                dir_ff, dir_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      wl_ff, wl_in;
   logic                      wr_ff, wr_in;
   logic [DIST_W-1:0]         dlf_ff, dlf_in;
   logic [DIST_W-1:0]         dlr_ff, dlr_in;
   logic [DIST_W-1:0]         drf_ff, drf_in;
   logic [DIST_W-1:0]         drr_ff, drr_in;

   // Registers of the write port
   logic [MOTOR_COUNT-1:0][TRIM_W-1:0] trim_ff;
   logic [DIST_W-1:0]                  limit_ff;
   logic [GAIN_W-1:0]                  gain_ff;

   // Datapath registers
   logic [TW-1:0]          total_ff, total_in;
   logic [KMAG_W-1:0]      kmag_ff, kmag_in;
   logic                   kneg_ff, kneg_in;
   logic [VMAG_W-1:0]      vmag_ff, vmag_in;
   logic                   vneg_ff, vneg_in;
   logic                   zero_ff, zero_in;
   logic [DW-1:0]          den_ff, den_in;
   logic [NW-1:0]          quo_ff, quo_in;
   logic                   qneg_ff, qneg_in;
   logic [CW-1:0]          corr_ff, corr_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   ca_ff, ca_in;
   logic                   cb_ff, cb_in;
   logic [MOTOR_IDX_W-1:0] rsp_motor_ff, rsp_motor_in;
   logic [PWM_W-1:0]       rsp_pwm_ff, rsp_pwm_in;
   logic                   rsp_a_ff, rsp_a_in;
   logic                   rsp_b_ff, rsp_b_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Internal nets
   logic                                  req_accept;
   logic                                  out_free;
   cnt_ctrl_type                          cnt_ctrl;
   logic [MOTOR_COUNT-1:0][STEP_BITS-1:0] step_count;
   logic [STEP_BITS-1:0]                  own;
   logic [TW-1:0]                         count_sum;
   logic [KW-1:0]                         k_val;
   logic [KW-1:0]                         k_abs;
   logic                                  front_pair;
   logic                                  dir_neg;
   logic [VMAG_W-1:0]                     smag;
   logic                                  div_start;
   div_status_type                        div_status;
   logic [NW-1:0]                         div_quo;
   logic                                  seen;
   logic [DIST_W-1:0]                     dist_f;
   logic [DIST_W-1:0]                     dist_r;
   logic signed [SPEED_W-1:0]             dist_diff;
   logic signed [WALL_W-1:0]              diff_ext;
   logic signed [WALL_W-1:0]              gain_ext;
   logic signed [WALL_W-1:0]              wall_mult;
   logic [WALL_W-1:0]                     far_term;
   logic signed [WALL_W-1:0]              wall_term;
   logic [CW-1:0]                         quo_ext;
   logic [CW-1:0]                         quo_signed;
   logic [CW-1:0]                         corr_mag;
   logic [MW-1:0]                         corr_mag_ext;
   logic [CLAMP_W-1:0]                    clamped;
   logic [PROD_W-1:0]                     rounded;
   logic [SCALED_W-1:0]                   scaled;
   logic [PWM_W-1:0]                      duty;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Step counter bank
   assign cnt_ctrl.sample = req_accept && (req_type == REQ_SAMPLE);
   assign cnt_ctrl.clear  = req_accept && (req_type == REQ_CLEAR);

   efwd_counts #(
      .STEP_BITS (STEP_BITS)
   ) u_counts (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cnt_ctrl),
      .enc_levels (req_enc_levels),
      .step_count (step_count)
   );

   // Shared divider
   efwd_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (kmag_ff * vmag_ff),
      .den    (den_ff),
      .status (div_status),
      .quo    (div_quo)
   );

   // Sum of the four counts and the balance factor 5*T - 16*n of one motor.
   always_comb begin
      count_sum = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         count_sum = count_sum + TW'(step_count[i]);
      end
      own   = step_count[motor_ff];
      k_val = ((KW'(total_ff) << 2) + KW'(total_ff)) - (KW'(own) << 4);
      k_abs = k_val[KW-1] ? (~k_val + KW'(1)) : k_val;
   end

   // Motor sign from the direction, and the speed magnitude.
   always_comb begin
      front_pair = !motor_ff[1];
      case (dir_ff)
         DIR_FRONT: dir_neg = 1'b0;
         DIR_RIGHT: dir_neg = !front_pair;
         DIR_LEFT:  dir_neg = front_pair;
         DIR_BACK:  dir_neg = 1'b1;
         default:   dir_neg = 1'b0;
      endcase
      smag = speed_ff[SPEED_W-1] ? (~speed_ff + VMAG_W'(1)) : speed_ff;
   end

   // Wall-following term, used for the front direction only.
   always_comb begin
      seen      = front_pair ? wl_ff : wr_ff;
      dist_f    = front_pair ? dlf_ff : drf_ff;
      dist_r    = front_pair ? dlr_ff : drr_ff;
      dist_diff = $signed({1'b0, dist_f}) - $signed({1'b0, dist_r});
      diff_ext  = WALL_W'(dist_diff);
      gain_ext  = $signed(WALL_W'(gain_ff));
      wall_mult = diff_ext * gain_ext;
      far_term  = WALL_FAR_STEP * WALL_W'(gain_ff);
      if ((dir_ff == DIR_FRONT) && seen) begin
         if ((dist_f > limit_ff) || (dist_r > limit_ff)) begin
            wall_term = $signed(far_term);
         end else begin
            wall_term = wall_mult;
         end
      end else begin
         wall_term = '0;
      end
   end

   // Signed correction, its clamped magnitude and the rounded duty.
   always_comb begin
      quo_ext      = CW'(quo_ff);
      quo_signed   = qneg_ff ? (~quo_ext + CW'(1)) : quo_ext;
      corr_mag     = corr_ff[CW-1] ? (~corr_ff + CW'(1)) : corr_ff;
      corr_mag_ext = MW'(corr_mag);
      clamped      = (corr_mag_ext > MW'(ABS_LIMIT)) ? ABS_LIMIT
                                                     : corr_mag_ext[CLAMP_W-1:0];
      rounded      = prod_ff + PROD_W'(ROUND_BIAS);
      scaled       = rounded[PROD_W-1:DUTY_SHIFT];
      duty         = (|scaled[SCALED_W-1:PWM_W]) ? PWM_MAX : scaled[PWM_W-1:0];
   end

   // Sequencer: a drive item sums the counts, then takes one motor at a time
   // through load, multiply, divide, adjust, duty and emit; a brake item only emits.
   always_comb begin
      state_in     = state_ff;
      motor_in     = motor_ff;
      brake_in     = brake_ff;
      dir_in       = dir_ff;
      speed_in     = speed_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      dlf_in       = dlf_ff;
      dlr_in       = dlr_ff;
      drf_in       = drf_ff;
      drr_in       = drr_ff;
      total_in     = total_ff;
      kmag_in      = kmag_ff;
      kneg_in      = kneg_ff;
      vmag_in      = vmag_ff;
      vneg_in      = vneg_ff;
      zero_in      = zero_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      qneg_in      = qneg_ff;
      corr_in      = corr_ff;
      prod_in      = prod_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      rsp_motor_in = rsp_motor_ff;
      rsp_pwm_in   = rsp_pwm_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               dir_in   = req_direction;
               speed_in = req_speed;
               wl_in    = req_wall_left;
               wr_in    = req_wall_right;
               dlf_in   = req_dist_left_front;
               dlr_in   = req_dist_left_rear;
               drf_in   = req_dist_right_front;
               drr_in   = req_dist_right_rear;
               motor_in = '0;
               if (req_type == REQ_DRIVE) begin
                  brake_in = 1'b0;
                  state_in = ST_SUM;
               end else if (req_type == REQ_BRAKE) begin
                  brake_in = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            total_in = count_sum;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            kmag_in  = k_abs[KMAG_W-1:0];
            kneg_in  = k_val[KW-1];
            vmag_in  = smag;
            vneg_in  = speed_ff[SPEED_W-1] ^ dir_neg;
            zero_in  = (own == '0);
            den_in   = {own, 2'b00};
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // A zero count skips the balance term.
            if (zero_ff) begin
               quo_in   = NW'(vmag_ff);
               qneg_in  = vneg_ff;
               state_in = ST_ADJ;
            end else begin
               qneg_in   = kneg_ff ^ vneg_ff;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               quo_in   = div_quo;
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            corr_in  = quo_signed + CW'(wall_term);
            state_in = ST_DUTY;
         end
         ST_DUTY: begin
            prod_in  = PROD_W'(clamped) * PROD_W'(trim_ff[motor_ff]);
            ca_in    = !corr_ff[CW-1];
            cb_in    = corr_ff[CW-1] || (corr_ff == '0);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_motor_in = motor_ff;
               rsp_pwm_in   = brake_ff ? '0 : duty;
               rsp_a_in     = brake_ff || ca_ff;
               rsp_b_in     = brake_ff || cb_ff;
               rsp_last_in  = (motor_ff == MOTOR_IDX_W'(MOTOR_COUNT - 1));
               motor_in     = motor_ff + MOTOR_IDX_W'(1);
               if (motor_ff == MOTOR_IDX_W'(MOTOR_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else if (!brake_ff) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= '0;
         brake_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         brake_ff     <= brake_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dir_ff       <= dir_in;
      speed_ff     <= speed_in;
      wl_ff        <= wl_in;
      wr_ff        <= wr_in;
      dlf_ff       <= dlf_in;
      dlr_ff       <= dlr_in;
      drf_ff       <= drf_in;
      drr_ff       <= drr_in;
      total_ff     <= total_in;
      kmag_ff      <= kmag_in;
      kneg_ff      <= kneg_in;
      vmag_ff      <= vmag_in;
      vneg_ff      <= vneg_in;
      zero_ff      <= zero_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      qneg_ff      <= qneg_in;
      corr_ff      <= corr_in;
      prod_ff      <= prod_in;
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_pwm_ff   <= rsp_pwm_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Register writes; writes to unused indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff  <= TRIM_RESET;
         limit_ff <= WALL_LIMIT_RESET;
         gain_ff  <= STEER_GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIM_0:     trim_ff[0] <= csr_wdata;
            CSR_TRIM_1:     trim_ff[1] <= csr_wdata;
            CSR_TRIM_2:     trim_ff[2] <= csr_wdata;
            CSR_TRIM_3:     trim_ff[3] <= csr_wdata;
            CSR_WALL_LIMIT: limit_ff   <= csr_wdata[DIST_W-1:0];
            CSR_STEER_GAIN: gain_ff    <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_index = rsp_motor_ff;
   assign rsp_pwm_duty    = rsp_pwm_ff;
   assign rsp_drive_a     = rsp_a_ff;
   assign rsp_drive_b     = rsp_b_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef ASSERT_OFF
   // A new result only appears out of the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result item raised outside the emit step");

   // The last result of a run belongs to the last motor.
   a_last_motor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_motor_ff == MOTOR_IDX_W'(MOTOR_COUNT - 1)))
      else $error("last result of a run on the wrong motor");

   // At least one bridge line is high in every result.
   a_bridge_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_a_ff || rsp_b_ff))
      else $error("both bridge lines low");

   // The divider only runs while the sequencer waits for it.
   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside the divide step");
`endif

endmodule

`default_nettype wire
